[rtl/mm4_pkg.sv]
// ----------------------------------------------------------------------------
// mm4_pkg: shared definitions of the 4x4 fixed-point matrix multiplier
// Action codes, default sizes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int VALUE_W           = 32;
  localparam int ACTION_W          = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  // Command from the controller to the datapath for one cycle.
  typedef struct packed {
    logic wr_a;       // write element of A from the input transaction
    logic wr_b;       // write element of B from the input transaction
    logic issue;      // read one A/B pair into the multiply pipeline
    logic first_k;    // first term of a product element
    logic last_k;     // final term of a product element
    logic last_elem;  // term belongs to the final product element
  } mm4_cmd_t;

endpackage

[rtl/mm4_ctrl.sv]
// ----------------------------------------------------------------------------
// mm4_ctrl: sequencer of the matrix multiplier
// Decodes input transactions and steps the element and term counters.
// ----------------------------------------------------------------------------
module mm4_ctrl #(
  parameter int  DIM       = mm4_pkg::DIM_DEFAULT,
  localparam int NUM_ELEMS = DIM * DIM,
  localparam int IDX_W     = $clog2(NUM_ELEMS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mm4_pkg::ACTION_W-1:0]  in_action,
  input  logic [IDX_W-1:0]              in_index,
  input  logic                          advance,
  output mm4_pkg::mm4_cmd_t             cmd,
  output logic [IDX_W-1:0]              addr_a,
  output logic [IDX_W-1:0]              addr_b,
  output logic [IDX_W-1:0]              elem_idx
);
  import mm4_pkg::*;

  localparam int K_W = $clog2(DIM);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   row_r, row_nxt;
  logic [K_W-1:0]   col_r, col_nxt;
  logic [IDX_W-1:0] e_r, e_nxt;
  logic             idx_ok;

  assign idx_ok   = ({1'b0, in_index} < (IDX_W+1)'(NUM_ELEMS));
  assign addr_a   = IDX_W'(int'(k_r) * DIM + int'(row_r));
  assign addr_b   = IDX_W'(int'(col_r) * DIM + int'(k_r));
  assign elem_idx = e_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    e_nxt         = e_r;
    cmd           = '0;
    cmd.first_k   = (k_r == '0);
    cmd.last_k    = (k_r == K_W'(DIM - 1));
    cmd.last_elem = (e_r == IDX_W'(NUM_ELEMS - 1));
    in_tready     = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.wr_a = (in_action == ACT_LOAD_A) && idx_ok;
          cmd.wr_b = (in_action == ACT_LOAD_B) && idx_ok;
          if (in_action == ACT_COMPUTE) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          cmd.issue = 1'b1;
          if (cmd.last_k) begin
            k_nxt = '0;
            if (cmd.last_elem) begin
              e_nxt     = '0;
              state_nxt = ST_IDLE;
            end else begin
              e_nxt = e_r + 1'b1;
            end
            if (row_r == K_W'(DIM - 1)) begin
              row_nxt = '0;
              col_nxt = (col_r == K_W'(DIM - 1)) ? '0 : col_r + 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      row_r   <= '0;
      col_r   <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      e_r     <= e_nxt;
    end
  end

endmodule

[rtl/mm4_datapath.sv]
// ----------------------------------------------------------------------------
// mm4_datapath: element stores, multiply-accumulate pipeline and output
// Read, multiply, accumulate, then shift, saturate and hold the result.
// ----------------------------------------------------------------------------
module mm4_datapath #(
  parameter int  DIM           = mm4_pkg::DIM_DEFAULT,
  parameter int  FRACTION_BITS = mm4_pkg::FRAC_BITS_DEFAULT,
  localparam int NUM_ELEMS     = DIM * DIM,
  localparam int IDX_W         = $clog2(NUM_ELEMS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mm4_pkg::mm4_cmd_t                   cmd,
  input  logic [IDX_W-1:0]                    addr_a,
  input  logic [IDX_W-1:0]                    addr_b,
  input  logic [IDX_W-1:0]                    elem_idx,
  input  logic [IDX_W-1:0]                    in_index,
  input  logic signed [mm4_pkg::VALUE_W-1:0]  in_value,
  output logic                                advance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mm4_pkg::VALUE_W-1:0]  out_value,
  output logic [IDX_W-1:0]                    out_index,
  output logic                                out_sat,
  output logic                                out_last
);
  import mm4_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-VALUE_W){1'b0}}, 1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-VALUE_W){1'b1}}, 1'b1, {(VALUE_W-1){1'b0}}};

  logic signed [VALUE_W-1:0] mem_a [NUM_ELEMS];
  logic signed [VALUE_W-1:0] mem_b [NUM_ELEMS];

  // Stage 1: registered reads
  logic                      s1_v_r;
  logic signed [VALUE_W-1:0] a_q_r, b_q_r;
  logic                      s1_first_r, s1_lastk_r, s1_elast_r;
  logic [IDX_W-1:0]          s1_eidx_r;
  // Stage 2: product
  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  s2_prod_r;
  logic                      s2_first_r, s2_lastk_r, s2_elast_r;
  logic [IDX_W-1:0]          s2_eidx_r;
  // Stage 3: accumulator
  logic                      s3_done_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      s3_elast_r;
  logic [IDX_W-1:0]          s3_eidx_r;
  // Output register
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0]          out_index_r;
  logic                      out_sat_r, out_sat_nxt;
  logic                      out_last_r;

  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted;

  // The whole pipeline moves only while the output slot can take a result.
  assign advance = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[in_index] <= in_value;
    end
    if (cmd.wr_b) begin
      mem_b[in_index] <= in_value;
    end
    if (advance && cmd.issue) begin
      a_q_r <= mem_a[addr_a];
      b_q_r <= mem_b[addr_b];
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){s2_prod_r[PROD_W-1]}}, s2_prod_r};
  assign acc_nxt  = s2_first_r ? prod_ext : acc_r + prod_ext;
  assign shifted  = acc_r >>> FRACTION_BITS;

  always_comb begin
    out_sat_nxt   = 1'b0;
    out_value_nxt = shifted[VALUE_W-1:0];
    if (shifted > SAT_MAX) begin
      out_value_nxt = SAT_MAX[VALUE_W-1:0];
      out_sat_nxt   = 1'b1;
    end else if (shifted < SAT_MIN) begin
      out_value_nxt = SAT_MIN[VALUE_W-1:0];
      out_sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_v_r      <= cmd.issue;
      s2_v_r      <= s1_v_r;
      s3_done_r   <= s2_v_r && s2_lastk_r;
      out_valid_r <= s3_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd.issue) begin
        s1_first_r <= cmd.first_k;
        s1_lastk_r <= cmd.last_k;
        s1_elast_r <= cmd.last_elem;
        s1_eidx_r  <= elem_idx;
      end
      if (s1_v_r) begin
        s2_prod_r  <= a_q_r * b_q_r;
        s2_first_r <= s1_first_r;
        s2_lastk_r <= s1_lastk_r;
        s2_elast_r <= s1_elast_r;
        s2_eidx_r  <= s1_eidx_r;
      end
      if (s2_v_r) begin
        acc_r      <= acc_nxt;
        s3_elast_r <= s2_elast_r;
        s3_eidx_r  <= s2_eidx_r;
      end
      if (s3_done_r) begin
        out_value_r <= out_value_nxt;
        out_sat_r   <= out_sat_nxt;
        out_index_r <= s3_eidx_r;
        out_last_r  <= s3_elast_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_sat   = out_sat_r;
  assign out_last  = out_last_r;

endmodule

[rtl/matrix_multiply_4x4_top.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_top: DIM x DIM signed Q16.16 matrix multiplier
// Loads elements of A and B one per transaction and streams out A times B.
// ----------------------------------------------------------------------------
// Usage: send load transactions (action 0 for A, 1 for B) with a column-major
// index col*DIM+row. A compute transaction (action 2) streams all DIM*DIM
// product elements in index order, the last one flagged on out_tlast, the
// clipped ones flagged on out_tuser. Each element is built one term per
// cycle while the output is not stalled, set by the single read port of each
// element store feeding one shared 32x32 multiplier; the last result passes
// the read, product, accumulator and output registers after its final term.
// The input is not ready while terms are issued; a stalled output holds the
// whole pipeline. Every element must be loaded before a compute reads it: the
// stores are not cleared by reset. Action 3 and load indexes beyond the
// matrix are dropped.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_top #(
  parameter int  DIM           = mm4_pkg::DIM_DEFAULT,
  parameter int  FRACTION_BITS = mm4_pkg::FRAC_BITS_DEFAULT,
  localparam int NUM_ELEMS     = DIM * DIM,
  localparam int IDX_W         = $clog2(NUM_ELEMS),
  localparam int DATA_W        = ((IDX_W + mm4_pkg::VALUE_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [DATA_W-1:0]             in_tdata,  // elem_index, elem_value, zero pad
  input  logic [mm4_pkg::ACTION_W-1:0]  in_tuser,  // action
  // Result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [DATA_W-1:0]             out_tdata, // prod_value, prod_index, zero pad
  output logic [0:0]                    out_tuser, // saturated
  output logic                          out_tlast
);
  import mm4_pkg::*;

  mm4_cmd_t                  cmd;
  logic                      advance;
  logic [IDX_W-1:0]          addr_a, addr_b, elem_idx;
  logic [IDX_W-1:0]          in_index;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [VALUE_W-1:0] out_value;
  logic [IDX_W-1:0]          out_index;
  logic                      out_sat;

  // Unpack the input transaction.
  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W +: VALUE_W];

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_index  (in_index),
    .advance   (advance),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .elem_idx  (elem_idx)
  );

  mm4_datapath #(
    .DIM           (DIM),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .elem_idx  (elem_idx),
    .in_index  (in_index),
    .in_value  (in_value),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value),
    .out_index (out_index),
    .out_sat   (out_sat),
    .out_last  (out_tlast)
  );

  // Pack the result transaction, value in the lowest bits.
  assign out_tdata = {{(DATA_W-IDX_W-VALUE_W){1'b0}}, out_index, out_value};
  assign out_tuser = out_sat;

endmodule

[rtl/mm4_checker.sv]
// ----------------------------------------------------------------------------
// mm4_checker: port-level checks of the matrix multiplier
// Watches the top-level channels and flags broken sequencing.
// ----------------------------------------------------------------------------
module mm4_checker #(
  parameter int  DIM       = mm4_pkg::DIM_DEFAULT,
  localparam int NUM_ELEMS = DIM * DIM,
  localparam int IDX_W     = $clog2(NUM_ELEMS),
  localparam int DATA_W    = ((IDX_W + mm4_pkg::VALUE_W + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [mm4_pkg::ACTION_W-1:0]  in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [DATA_W-1:0]             out_tdata,
  input logic [0:0]                    out_tuser,
  input logic                          out_tlast
);
  import mm4_pkg::*;

  logic [IDX_W-1:0]   out_index;
  logic [VALUE_W-1:0] out_value;

  assign out_value = out_tdata[VALUE_W-1:0];
  assign out_index = out_tdata[VALUE_W +: IDX_W];

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The last flag marks exactly the final element.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_index == IDX_W'(NUM_ELEMS - 1))))
    else $error("last flag does not match final element index");

  // A clipped element carries one of the two range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_value == 32'h7FFF_FFFF) || (out_value == 32'h8000_0000))
    else $error("saturated element is not a range limit");

  // A compute transaction blocks the input while its terms are issued.
  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_COMPUTE) |=> !in_tready)
    else $error("input accepted right after a compute");

endmodule

bind matrix_multiply_4x4_top mm4_checker #(
  .DIM (DIM)
) u_mm4_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
